// ===== hdl/sbfc_pkg.sv =====
// Shared widths, types and codes for the swept box versus face collision block.
package sbfc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 21;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int WIDE_W    = COORD_W + 4;
  localparam int DIV_W     = COORD_W + 2;
  localparam int PROD_W    = COORD_W + T_W;
  localparam int DISP_W    = PROD_W - (FRAC_BITS - 1);
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic [DIV_W-1:0]          div_word_t;
  typedef logic [T_W-1:0]            tval_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [DISP_W-1:0]         disp_t;
  typedef logic [1:0]                axis_t;
  typedef logic [IDX_W-1:0]          reg_idx_t;

  localparam axis_t AXIS_X    = 2'd0;
  localparam axis_t AXIS_Y    = 2'd1;
  localparam axis_t AXIS_Z    = 2'd2;
  localparam axis_t AXIS_NONE = 2'd3;

  localparam reg_idx_t REG_BOX_X  = 3'd0;
  localparam reg_idx_t REG_BOX_Y  = 3'd1;
  localparam reg_idx_t REG_BOX_Z  = 3'd2;
  localparam reg_idx_t REG_FACE_X = 3'd3;
  localparam reg_idx_t REG_FACE_Y = 3'd4;
  localparam reg_idx_t REG_FACE_Z = 3'd5;

  localparam size_t SIZE_ONE = size_t'(1 << FRAC_BITS);

  // one of the two axes that lie in the face plane
  typedef struct packed {
    coord_t bc;
    coord_t fc;
    coord_t mv;
  } side_t;

  typedef struct packed {
    coord_t [2:0] bc;
    coord_t [2:0] fc;
    coord_t [2:0] mv;
    axis_t        axis;
  } query_t;

  typedef struct packed {
    logic         rej;
    axis_t        axis;
    side_t  [1:0] side;
    wide_t        n;
    wide_t        d;
  } gap_t;

  typedef struct packed {
    logic         rej;
    axis_t        axis;
    side_t  [1:0] side;
    div_word_t    r;
    div_word_t    d;
    tval_t        q;
  } div_t;

  typedef struct packed {
    logic         rej;
    axis_t        axis;
    tval_t        t;
    side_t  [1:0] side;
    disp_t  [1:0] p;
  } disp_stage_t;

  typedef struct packed {
    logic         rej;
    axis_t        axis;
    tval_t        t;
    wide_t  [1:0] c2;
    wide_t  [1:0] fc2;
  } pos_t;

  typedef struct packed {
    logic  hit;
    tval_t impact_time;
  } result_t;

endpackage

// ===== hdl/sbfc_in_if.sv =====
// Query channel: one beat carries box, face and motion of one collision query.
interface sbfc_in_if import sbfc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t box_center_x;
  coord_t box_center_y;
  coord_t box_center_z;
  coord_t face_center_x;
  coord_t face_center_y;
  coord_t face_center_z;
  axis_t  face_axis;
  coord_t move_x;
  coord_t move_y;
  coord_t move_z;

  modport source (
    output valid, box_center_x, box_center_y, box_center_z,
    output face_center_x, face_center_y, face_center_z, face_axis,
    output move_x, move_y, move_z,
    input  ready
  );
  modport sink (
    input  valid, box_center_x, box_center_y, box_center_z,
    input  face_center_x, face_center_y, face_center_z, face_axis,
    input  move_x, move_y, move_z,
    output ready
  );
endinterface

// ===== hdl/sbfc_out_if.sv =====
// Result channel: one beat carries the hit flag and time of impact of one query.
interface sbfc_out_if import sbfc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  hit;
  tval_t impact_time;

  modport source (output valid, hit, impact_time, input ready);
  modport sink (input valid, hit, impact_time, output ready);
endinterface

// ===== hdl/swept_box_face_collision.sv =====
// Swept box versus axis-aligned face: hit flag and time of impact, one query per cycle
// unless the result side holds back. Each query passes one input stage, one stage for the
// gap and speed along the face normal, a restoring divider of FRAC_BITS+1 stages that yields
// one bit of the impact time per stage, one multiply stage for the in-plane displacement,
// one stage for the moved position and the output register with the overlap test. Each
// stage advances on its own, so bubbles close up and a waiting result does not stop new
// queries from entering until the stages behind it are full. Box and face sizes sit in six
// APB registers at byte addresses 0 to 20 in steps of 4;
// write them only while no query is in flight.
module swept_box_face_collision import sbfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sbfc_in_if.sink           in_s,
  sbfc_out_if.source        out_s,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  size_t [2:0] box_size_r;
  size_t [2:0] face_size_r;

  query_t      s1_r;
  logic        s1_v_r;
  gap_t        s2_r, s2_nxt;
  logic        s2_v_r;
  div_t        div_r   [0:FRAC_BITS];
  div_t        div_nxt [0:FRAC_BITS];
  logic [FRAC_BITS:0] div_v_r;
  disp_stage_t m_r, m_nxt;
  logic        m_v_r;
  pos_t        a_r, a_nxt;
  logic        a_v_r;
  result_t     o_r, o_nxt;
  logic        o_v_r;

  logic               ld_1, ld_2, ld_m, ld_a, ld_o;
  logic [FRAC_BITS:0] ld_div;

  function automatic wide_t dbl(input coord_t c);
    return wide_t'(c) <<< 1;
  endfunction

  function automatic wide_t zext(input size_t s);
    return $signed({{(WIDE_W-SIZE_W){1'b0}}, s});
  endfunction

  // in-plane axes for a given face normal
  function automatic axis_t ax_u(input axis_t a);
    return (a == AXIS_X) ? AXIS_Y : AXIS_X;
  endfunction

  function automatic axis_t ax_v(input axis_t a);
    return (a == AXIS_Z) ? AXIS_Y : AXIS_Z;
  endfunction

  // ---------------- configuration registers ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_size_r  <= {3{SIZE_ONE}};
      face_size_r <= {3{SIZE_ONE}};
    end else if (psel && penable && pwrite) begin
      case (paddr[ADDR_W-1:2])
        REG_BOX_X:  box_size_r[0]  <= pwdata[SIZE_W-1:0];
        REG_BOX_Y:  box_size_r[1]  <= pwdata[SIZE_W-1:0];
        REG_BOX_Z:  box_size_r[2]  <= pwdata[SIZE_W-1:0];
        REG_FACE_X: face_size_r[0] <= pwdata[SIZE_W-1:0];
        REG_FACE_Y: face_size_r[1] <= pwdata[SIZE_W-1:0];
        REG_FACE_Z: face_size_r[2] <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_BOX_X:  prdata = DATA_W'(box_size_r[0]);
      REG_BOX_Y:  prdata = DATA_W'(box_size_r[1]);
      REG_BOX_Z:  prdata = DATA_W'(box_size_r[2]);
      REG_FACE_X: prdata = DATA_W'(face_size_r[0]);
      REG_FACE_Y: prdata = DATA_W'(face_size_r[1]);
      REG_FACE_Z: prdata = DATA_W'(face_size_r[2]);
      default:    prdata = '0;
    endcase
  end

  // ---------------- stage advance ----------------
  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld_o              = !o_v_r || out_s.ready;
    ld_a              = !a_v_r || ld_o;
    ld_m              = !m_v_r || ld_a;
    ld_div[FRAC_BITS] = !div_v_r[FRAC_BITS] || ld_m;
    for (int k = FRAC_BITS - 1; k >= 0; k--) begin
      ld_div[k] = !div_v_r[k] || ld_div[k+1];
    end
    ld_2 = !s2_v_r || ld_div[0];
    ld_1 = !s1_v_r || ld_2;
  end

  assign in_s.ready = ld_1;

  // ---------------- gap and speed along the face normal ----------------
  always_comb begin
    axis_t  sel, u, v;
    coord_t a_bc, a_fc, a_mv;
    wide_t  bs, n_pos, n_neg;
    logic   mv_pos, mv_zero;
    sel     = (s1_r.axis == AXIS_NONE) ? AXIS_X : s1_r.axis;
    u       = ax_u(sel);
    v       = ax_v(sel);
    a_bc    = s1_r.bc[sel];
    a_fc    = s1_r.fc[sel];
    a_mv    = s1_r.mv[sel];
    bs      = zext(box_size_r[sel]);
    mv_zero = (a_mv == '0);
    mv_pos  = !a_mv[COORD_W-1] && !mv_zero;
    n_pos   = dbl(a_fc) - dbl(a_bc) - bs;
    n_neg   = dbl(a_bc) - bs - dbl(a_fc);
    s2_nxt.rej        = (s1_r.axis == AXIS_NONE) || mv_zero;
    s2_nxt.axis       = sel;
    s2_nxt.side[0].bc = s1_r.bc[u];
    s2_nxt.side[0].fc = s1_r.fc[u];
    s2_nxt.side[0].mv = s1_r.mv[u];
    s2_nxt.side[1].bc = s1_r.bc[v];
    s2_nxt.side[1].fc = s1_r.fc[v];
    s2_nxt.side[1].mv = s1_r.mv[v];
    s2_nxt.n          = mv_pos ? n_pos : n_neg;
    s2_nxt.d          = mv_pos ? dbl(a_mv) : -dbl(a_mv);
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  always_comb begin
    wide_t     diff;
    logic      ge0;
    div_word_t r2;
    logic      ge;
    diff = s2_r.n - s2_r.d;
    ge0  = (s2_r.n >= s2_r.d);
    // reject a box on the wrong side or contact beyond one step
    div_nxt[0].rej  = s2_r.rej || s2_r.n[WIDE_W-1] || (s2_r.n > s2_r.d);
    div_nxt[0].axis = s2_r.axis;
    div_nxt[0].side = s2_r.side;
    div_nxt[0].r    = ge0 ? diff[DIV_W-1:0] : s2_r.n[DIV_W-1:0];
    div_nxt[0].d    = s2_r.d[DIV_W-1:0];
    div_nxt[0].q    = {{(T_W-1){1'b0}}, ge0};
    for (int k = 1; k <= FRAC_BITS; k++) begin
      r2 = {div_r[k-1].r[DIV_W-2:0], 1'b0};
      ge = (r2 >= div_r[k-1].d);
      div_nxt[k]   = div_r[k-1];
      div_nxt[k].r = ge ? (r2 - div_r[k-1].d) : r2;
      div_nxt[k].q = {div_r[k-1].q[T_W-2:0], ge};
    end
  end

  // ---------------- displacement magnitude: |move| * t / 2^(FRAC_BITS-1) ----------------
  always_comb begin
    logic [COORD_W-1:0] raw, mag;
    logic [PROD_W-1:0]  prod;
    m_nxt.rej  = div_r[FRAC_BITS].rej;
    m_nxt.axis = div_r[FRAC_BITS].axis;
    m_nxt.t    = div_r[FRAC_BITS].q;
    m_nxt.side = div_r[FRAC_BITS].side;
    for (int j = 0; j < 2; j++) begin
      raw        = div_r[FRAC_BITS].side[j].mv;
      mag        = raw[COORD_W-1] ? (~raw + 1'b1) : raw;
      prod       = PROD_W'(mag) * PROD_W'(div_r[FRAC_BITS].q);
      m_nxt.p[j] = prod[PROD_W-1:FRAC_BITS-1];
    end
  end

  // ---------------- moved box centre in doubled units ----------------
  always_comb begin
    wide_t pw;
    a_nxt.rej  = m_r.rej;
    a_nxt.axis = m_r.axis;
    a_nxt.t    = m_r.t;
    for (int j = 0; j < 2; j++) begin
      pw           = $signed({{(WIDE_W-DISP_W){1'b0}}, m_r.p[j]});
      a_nxt.c2[j]  = dbl(m_r.side[j].bc) + (m_r.side[j].mv[COORD_W-1] ? -pw : pw);
      a_nxt.fc2[j] = dbl(m_r.side[j].fc);
    end
  end

  // ---------------- strict overlap on both in-plane axes ----------------
  always_comb begin
    axis_t       u, v;
    wide_t [1:0] bs, fs;
    logic  [1:0] ov;
    u     = ax_u(a_r.axis);
    v     = ax_v(a_r.axis);
    bs[0] = zext(box_size_r[u]);
    bs[1] = zext(box_size_r[v]);
    fs[0] = zext(face_size_r[u]);
    fs[1] = zext(face_size_r[v]);
    for (int j = 0; j < 2; j++) begin
      ov[j] = (a_r.c2[j] + bs[j] > a_r.fc2[j] - fs[j]) &&
              (a_r.fc2[j] + fs[j] > a_r.c2[j] - bs[j]);
    end
    o_nxt.hit         = !a_r.rej && ov[0] && ov[1];
    o_nxt.impact_time = o_nxt.hit ? a_r.t : '0;
  end

  // ---------------- stage registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      div_v_r <= '0;
      m_v_r   <= 1'b0;
      a_v_r   <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      if (ld_1) s1_v_r <= in_s.valid;
      if (ld_2) s2_v_r <= s1_v_r;
      if (ld_div[0]) div_v_r[0] <= s2_v_r;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        if (ld_div[k]) div_v_r[k] <= div_v_r[k-1];
      end
      if (ld_m) m_v_r <= div_v_r[FRAC_BITS];
      if (ld_a) a_v_r <= m_v_r;
      if (ld_o) o_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_1) begin
      s1_r.bc[0] <= in_s.box_center_x;
      s1_r.bc[1] <= in_s.box_center_y;
      s1_r.bc[2] <= in_s.box_center_z;
      s1_r.fc[0] <= in_s.face_center_x;
      s1_r.fc[1] <= in_s.face_center_y;
      s1_r.fc[2] <= in_s.face_center_z;
      s1_r.mv[0] <= in_s.move_x;
      s1_r.mv[1] <= in_s.move_y;
      s1_r.mv[2] <= in_s.move_z;
      s1_r.axis  <= in_s.face_axis;
    end
    if (ld_2) s2_r <= s2_nxt;
    for (int k = 0; k <= FRAC_BITS; k++) begin
      if (ld_div[k]) div_r[k] <= div_nxt[k];
    end
    if (ld_m) m_r <= m_nxt;
    if (ld_a) a_r <= a_nxt;
    if (ld_o) o_r <= o_nxt;
  end

  assign out_s.valid       = o_v_r;
  assign out_s.hit         = o_r.hit;
  assign out_s.impact_time = o_r.impact_time;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the swept box versus face collision block.
module tb_top import sbfc_pkg::*; ();

  localparam int     Q_ONE           = 1 << FRAC_BITS;
  localparam int     Q_HALF          = Q_ONE / 2;
  localparam coord_t C_MAX           = 32'h7fff_ffff;
  localparam coord_t C_MIN           = 32'h8000_0000;
  localparam coord_t C_QTR           = 32'h4000_0000;
  localparam size_t  EXTENT_MAX      = size_t'(1 << 20);
  localparam reg_idx_t REG_SPARE_LO  = 3'd6;
  localparam reg_idx_t REG_SPARE_HI  = 3'd7;
  localparam int     BLOCK_ITEMS     = 160;
  localparam int     SETTLE_CYCLES   = 30;   // pipeline is 22 deep
  localparam int     HOLD_CYCLES     = 150;
  localparam int     WATCHDOG_CYCLES = 2000;

  typedef enum {
    SET_RANDOM, SET_MAX, SET_BOX_ZERO, SET_FACE_ZERO, SET_NEAR_ONE, SET_RESET
  } size_plan_t;

  typedef struct packed {
    coord_t  bx, by, bz, fx, fy, fz;
    axis_t   ax;
    coord_t  mx, my, mz;
    logic    pinned;
    logic    hit;
    tval_t   t;
  } probe_row_t;

  // pinned rows carry their own answer at reset sizes; the rest go through the predictor
  localparam probe_row_t PROBES [20] = '{
    '{0, 0, 0, 0, 0, 0, AXIS_X, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 0, Q_ONE, 0, AXIS_Y, Q_ONE, 0, Q_ONE, 1, 0, 0},
    '{0, 0, 0, Q_ONE, 0, 0, AXIS_X, Q_ONE, 0, 0, 1, 1, Q_HALF},
    '{0, 0, 0, Q_ONE + Q_HALF, 0, 0, AXIS_X, Q_ONE, 0, 0, 1, 1, Q_ONE},
    '{0, 0, 0, 2 * Q_ONE, 0, 0, AXIS_X, Q_ONE, 0, 0, 1, 0, 0},
    '{0, 0, 0, Q_HALF, 0, 0, AXIS_X, Q_ONE, 0, 0, 1, 1, 0},
    '{0, 0, 0, -Q_ONE, 0, 0, AXIS_X, -Q_ONE, 0, 0, 1, 1, Q_HALF},
    '{0, 0, 0, 0, 0, 0, AXIS_X, Q_ONE, 0, 0, 1, 0, 0},
    '{0, 0, 0, Q_ONE, 0, 0, AXIS_X, -Q_ONE, 0, 0, 1, 0, 0},
    '{0, 0, 0, Q_ONE, Q_ONE, 0, AXIS_X, Q_ONE, 0, 0, 1, 0, 0},
    '{0, 0, 0, Q_ONE, Q_ONE - 1, 0, AXIS_X, Q_ONE, 0, 0, 1, 1, Q_HALF},
    '{0, 0, 0, Q_ONE, 0, -Q_ONE, AXIS_X, Q_ONE, 0, 0, 1, 0, 0},
    '{0, 0, 0, Q_ONE, Q_ONE, 0, AXIS_X, Q_ONE, Q_ONE, 0, 0, 0, 0},
    '{0, 0, 0, 0, Q_ONE, 0, AXIS_Y, 0, Q_ONE, 0, 1, 1, Q_HALF},
    '{0, 0, 0, 0, 0, -Q_ONE, AXIS_Z, 0, 0, -Q_ONE, 1, 1, Q_HALF},
    '{0, 0, 0, Q_ONE, 0, 0, AXIS_NONE, Q_ONE, 0, 0, 1, 0, 0},
    '{C_MAX, 0, 0, C_MIN, 0, 0, AXIS_X, C_MIN, 0, 0, 0, 0, 0},
    '{0, C_MAX, C_MIN, C_QTR, C_MAX, C_MIN, AXIS_X, C_MAX, 0, 0, 0, 0, 0},
    '{0, -C_QTR, C_QTR, Q_ONE + Q_HALF, C_QTR, -C_QTR, AXIS_X, Q_ONE, C_MAX, C_MIN,
      0, 0, 0},
    '{-1, -1, -1, -1, -1, -1, AXIS_NONE, -1, -1, -1, 1, 0, 0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  sbfc_in_if  in_ch ();
  sbfc_out_if out_ch ();

  swept_box_face_collision dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_ch),
    .out_s   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  size_t   size_regs [0:REG_FACE_Z];
  result_t expected_impacts [$];
  int      send_idle_pct  = 18;
  int      recv_idle_pct  = 57;
  bit      hold_output    = 1'b0;
  int      mismatches     = 0;
  int      reg_mismatches = 0;
  int      queries_sent   = 0;
  int      results_seen   = 0;
  int      hits_seen      = 0;
  int      quiet_cycles   = 0;

  // Time of impact and contact test in doubled coordinates.
  function automatic result_t predict_impact(query_t q);
    result_t r;
    longint bc2, fc2, bs, mv, n, d, c2, span, disp;
    longint unsigned mag;
    tval_t t;
    int ax, a;
    r = '0;
    if (q.axis == AXIS_NONE) return r;
    ax  = int'(q.axis);
    mv  = longint'($signed(q.mv[ax]));
    bc2 = 2 * longint'($signed(q.bc[ax]));
    fc2 = 2 * longint'($signed(q.fc[ax]));
    bs  = longint'(size_regs[int'(REG_BOX_X) + ax]);
    if (mv == 0) return r;
    if (mv > 0 && fc2 >= bc2 + bs) begin
      n = fc2 - bc2 - bs;
      d = 2 * mv;
    end else if (mv < 0 && fc2 <= bc2 - bs) begin
      n = bc2 - bs - fc2;
      d = -2 * mv;
    end else begin
      return r;
    end
    if (n > d) return r;
    t = tval_t'((n << FRAC_BITS) / d);
    for (a = 0; a < 3; a++) begin
      if (a == ax) continue;
      mv   = longint'($signed(q.mv[a]));
      mag  = (mv < 0) ? -mv : mv;
      disp = longint'((mag * t) >> (FRAC_BITS - 1));
      if (mv < 0) disp = -disp;
      c2   = 2 * longint'($signed(q.bc[a])) + disp - 2 * longint'($signed(q.fc[a]));
      span = longint'(size_regs[int'(REG_BOX_X) + a]) +
             longint'(size_regs[int'(REG_FACE_X) + a]);
      if (!(c2 < span && c2 > -span)) return r;
    end
    r.hit = 1'b1;
    r.impact_time = t;
    return r;
  endfunction

  // Mostly boxes placed ahead of the face and aimed at it; the rest noise and corner cases.
  function automatic query_t random_query();
    query_t q;
    longint bcv [3];
    longint fcv [3];
    longint mvv [3];
    longint gap, speed, half, span, off, lat;
    int ax, a, kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      for (a = 0; a < 3; a++) begin
        q.bc[a] = $urandom;
        q.fc[a] = $urandom;
        q.mv[a] = $urandom;
      end
      q.axis = axis_t'($urandom_range(0, 3));
      return q;
    end
    ax = $urandom_range(0, 2);
    for (a = 0; a < 3; a++) fcv[a] = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    gap   = $urandom_range(0, 1 << 20);
    speed = longint'($urandom_range(1, 1 << 20));
    // most reach the face within the step, some fall short
    if ($urandom_range(0, 7) != 0) speed += gap;
    half = (longint'(size_regs[int'(REG_BOX_X) + ax]) + 1) / 2;
    if ($urandom_range(0, 1) != 0) begin
      bcv[ax] = fcv[ax] - gap - half;
      mvv[ax] = speed;
    end else begin
      bcv[ax] = fcv[ax] + gap + half;
      mvv[ax] = -speed;
    end
    for (a = 0; a < 3; a++) begin
      if (a == ax) continue;
      span = longint'(size_regs[int'(REG_BOX_X) + a]) +
             longint'(size_regs[int'(REG_FACE_X) + a]);
      off  = longint'($urandom_range(0, int'(5 * span / 4))) - 5 * span / 8;
      lat  = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
      mvv[a] = lat;
      // back off by the expected lateral travel so the offset holds at contact
      bcv[a] = fcv[a] + off - lat * gap / speed;
    end
    for (a = 0; a < 3; a++) begin
      q.bc[a] = coord_t'(bcv[a]);
      q.fc[a] = coord_t'(fcv[a]);
      q.mv[a] = coord_t'(mvv[a]);
    end
    q.axis = axis_t'(ax);
    if (kind < 30) begin
      a = (ax + 1) % 3;
      case (kind % 5)
        0: q.axis = AXIS_NONE;
        1: q.mv[ax] = '0;
        2: q.bc[ax] = coord_t'(fcv[ax] + longint'($urandom_range(0, int'(2 * half + 2)))
                               - half - 1);
        3: begin
          // park the box exactly on the face edge
          span = longint'(size_regs[int'(REG_BOX_X) + a]) +
                 longint'(size_regs[int'(REG_FACE_X) + a]);
          q.mv[a] = '0;
          q.bc[a] = coord_t'(fcv[a] + (($urandom_range(0, 1) != 0) ? span / 2 : -(span / 2)));
        end
        default: begin
          q.mv[a] = $urandom;
          q.mv[(ax + 2) % 3] = $urandom;
        end
      endcase
    end
    return q;
  endfunction

  task automatic apb_access(input logic wr, input int idx, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_size_reg(int idx);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd[SIZE_W-1:0] !== size_regs[idx]) begin
      $display("%0t: register %0d readback, expected %0d, got %0d",
               $time, idx, size_regs[idx], rd[SIZE_W-1:0]);
      reg_mismatches++;
    end
  endtask

  task automatic program_sizes(size_plan_t plan);
    int i;
    bit is_box;
    size_t v;
    logic [DATA_W-1:0] rd;
    for (i = int'(REG_BOX_X); i <= int'(REG_SPARE_HI); i++) begin
      is_box = (i <= int'(REG_BOX_Z));
      case (plan)
        SET_RANDOM:    v = $urandom_range(0, EXTENT_MAX);
        SET_MAX:       v = EXTENT_MAX;
        SET_BOX_ZERO:  v = is_box ? size_t'(0) : EXTENT_MAX;
        SET_FACE_ZERO: v = is_box ? EXTENT_MAX : size_t'(0);
        SET_NEAR_ONE:  v = $urandom_range(SIZE_ONE / 4, 4 * SIZE_ONE);
        default:       v = SIZE_ONE;
      endcase
      // unmapped slots take junk and must change nothing
      if (i >= int'(REG_SPARE_LO)) v = size_t'($urandom);
      apb_access(1'b1, i, DATA_W'(v), rd);
      if (i <= int'(REG_FACE_Z)) begin
        size_regs[i] = v;
        verify_size_reg(i);
      end
    end
  endtask

  task automatic send_query(query_t q, result_t want);
    int idle;
    idle = 0;
    while ($urandom_range(0, 99) < send_idle_pct) idle++;
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.box_center_x  <= q.bc[0];
    in_ch.box_center_y  <= q.bc[1];
    in_ch.box_center_z  <= q.bc[2];
    in_ch.face_center_x <= q.fc[0];
    in_ch.face_center_y <= q.fc[1];
    in_ch.face_center_z <= q.fc[2];
    in_ch.face_axis     <= q.axis;
    in_ch.move_x        <= q.mv[0];
    in_ch.move_y        <= q.mv[1];
    in_ch.move_z        <= q.mv[2];
    do @(posedge clk); while (!in_ch.ready);
    expected_impacts.push_back(want);
    queries_sent++;
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_impacts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (hold_output && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.hit === 1'b1) hits_seen++;
      if (expected_impacts.size() == 0) begin
        $display("%0t: result beat with nothing pending, hit %0b impact_time %0d",
                 $time, out_ch.hit, out_ch.impact_time);
        mismatches++;
      end else begin
        result_t want;
        want = expected_impacts.pop_front();
        if (out_ch.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, out_ch.hit);
          mismatches++;
        end
        if (out_ch.impact_time !== want.impact_time) begin
          $display("%0t: impact_time mismatch, expected %0d, got %0d",
                   $time, want.impact_time, out_ch.impact_time);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no beat for %0d cycles, %0d results still pending",
               $time, quiet_cycles, expected_impacts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    query_t     q;
    probe_row_t row;
    result_t    want;
    int         i, b;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.box_center_x  <= '0;
    in_ch.box_center_y  <= '0;
    in_ch.box_center_z  <= '0;
    in_ch.face_center_x <= '0;
    in_ch.face_center_y <= '0;
    in_ch.face_center_z <= '0;
    in_ch.face_axis     <= AXIS_X;
    in_ch.move_x        <= '0;
    in_ch.move_y        <= '0;
    in_ch.move_z        <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    for (i = int'(REG_BOX_X); i <= int'(REG_FACE_Z); i++) size_regs[i] = SIZE_ONE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = int'(REG_BOX_X); i <= int'(REG_FACE_Z); i++) verify_size_reg(i);

    for (i = 0; i < $size(PROBES); i++) begin
      row = PROBES[i];
      q.bc[0] = row.bx; q.bc[1] = row.by; q.bc[2] = row.bz;
      q.fc[0] = row.fx; q.fc[1] = row.fy; q.fc[2] = row.fz;
      q.mv[0] = row.mx; q.mv[1] = row.my; q.mv[2] = row.mz;
      q.axis  = row.ax;
      want.hit = row.hit;
      want.impact_time = row.t;
      send_query(q, row.pinned ? want : predict_impact(q));
    end

    // six size settings; idle pattern switches every two of them
    for (b = 0; b < 6; b++) begin
      drain_pipeline();
      send_idle_pct = (b < 2) ? 18 : (b < 4) ? 57 : 0;
      recv_idle_pct = (b < 2) ? 57 : (b < 4) ? 18 : 0;
      program_sizes(size_plan_t'(b));
      if (b == 4) hold_output = 1'b1;
      repeat (BLOCK_ITEMS) begin
        q = random_query();
        send_query(q, predict_impact(q));
      end
    end
    drain_pipeline();

    $display("Sent %0d queries over six size settings, checked %0d results (%0d hits).",
             queries_sent, results_seen, hits_seen);
    $display("Mismatches: %0d", mismatches + reg_mismatches);
    if (mismatches == 0 && reg_mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
